### rtl/core/sdfr_pkg.sv
package sdfr_pkg;

    // Build defaults
    localparam int LINE_MAX_DEFAULT    = 64;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    typedef enum logic [1:0] {
        REG_SCALE   = 2'd0,
        REG_OFFSET  = 2'd1,
        REG_TIMEOUT = 2'd2
    } reg_index_t;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // Characters the parser cares about
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Magnitude cap: 2^31, enough for the most negative value
    localparam logic [31:0] MAG_CAP     = 32'h8000_0000;
    localparam logic [31:0] RAW_POS_MAX = 32'h7FFF_FFFF;

    // Input and result words
    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic              reading_valid;
        logic signed [31:0] raw_value;
        logic signed [31:0] force_q16;
        logic              connected;
    } result_t;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_READING = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        negative;
        logic [31:0] magnitude;
    } cmd_t;

    // Calibration settings seen by the back end
    typedef struct packed {
        logic               scale_neg;
        logic [39:0]        scale_mag;
        logic signed [22:0] offset_q16;
        logic [15:0]        timeout_ms;
    } cfg_t;

endpackage

### rtl/core/serial_decimal_force_reader_top.sv
// Serial decimal force reader.
// Input channel (item_valid/item_ready/item): each word is either a received
// UART byte (op = 0) or a one millisecond tick (op = 1). Bytes form lines that
// end at CR or LF; the line is parsed as a signed decimal on the fly.
// Output channel (result_valid/result_ready/result): exactly one word per input
// word, in order. reading_valid marks the word that closed a good line; raw_value
// and force_q16 hold the latest reading; connected is high while the tick count
// since that reading is below timeout_ms.
// APB port: scale_q40 at 0x00, offset_q16 at 0x08, timeout_ms at 0x10.
// Throughput: one word per cycle while result_ready does not stall the output.
// Path: front parse into the queue, multiply stage, round stage, then
// the output register with offset add and saturation.
// Reset clears the parser, held values and tick count, sets timeout_ms to 1000
// and scale and offset to 0; no clearing pass is needed.
// When the receiver stalls, the back pipeline freezes; the front keeps taking
// words into a QUEUE_DEPTH-deep queue and drops item_ready once it is full.
module serial_decimal_force_reader_top
    import sdfr_pkg::*;
#(
    parameter int LINE_MAX    = LINE_MAX_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    sdfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdfr_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .queue_full (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    sdfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .empty     (q_empty),
        .full      (q_full)
    );

    sdfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd_valid    (!q_empty),
        .cmd          (pop_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### rtl/core/sdfr_regs.sv
module sdfr_regs
    import sdfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [39:0] scale_reg;
    logic [39:0] scale_mag_reg;
    logic [22:0] offset_reg;
    logic [15:0] timeout_reg;
    logic [39:0] scale_mag_next;
    logic        wr_en;
    logic [1:0]  index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[4:3];

    // Magnitude of the new scale word, kept beside it for the multiplier
    assign scale_mag_next = pwdata[39] ? (40'd0 - pwdata[39:0]) : pwdata[39:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= '0;
            scale_mag_reg <= '0;
            offset_reg    <= '0;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_SCALE:
                begin
                    scale_reg     <= pwdata[39:0];
                    scale_mag_reg <= scale_mag_next;
                end
                REG_OFFSET:  offset_reg  <= pwdata[22:0];
                REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (index)
            REG_SCALE:   prdata = {24'd0, scale_reg};
            REG_OFFSET:  prdata = {41'd0, offset_reg};
            REG_TIMEOUT: prdata = {48'd0, timeout_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.scale_neg  = scale_reg[39];
    assign cfg.scale_mag  = scale_mag_reg;
    assign cfg.offset_q16 = $signed(offset_reg);
    assign cfg.timeout_ms = timeout_reg;

endmodule

### rtl/core/sdfr_front.sv
module sdfr_front
    import sdfr_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    input  item_t item,
    output logic  item_ready,
    input  logic  queue_full,
    output logic  push,
    output cmd_t  cmd
);

    localparam int CNT_W = $clog2(LINE_MAX);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_MAX - 1);

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_DONE   = 3'd3,
        PH_FAIL   = 3'd4
    } phase_t;

    logic [CNT_W-1:0] count_reg, count_next;
    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [31:0]      mag_reg, mag_next;

    logic [7:0]  ch;
    logic        is_digit;
    logic        is_blank;
    logic [35:0] mag_x10;
    logic [31:0] mag_acc;

    assign item_ready = !queue_full;
    assign push       = item_valid && !queue_full;
    assign ch         = item.rx_byte;

    // Digit accumulate with saturation at 2^31
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_blank = (ch == CH_SPACE) || (ch == CH_HT) || (ch == CH_VT) || (ch == CH_FF);
    assign mag_x10  = ({4'd0, mag_reg} << 3) + ({4'd0, mag_reg} << 1) + {32'd0, ch[3:0]};
    assign mag_acc  = (mag_x10 > {4'd0, MAG_CAP}) ? MAG_CAP : mag_x10[31:0];

    // Line and parse state
    always_comb
    begin
        count_next    = count_reg;
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        cmd.kind      = CMD_NONE;
        cmd.negative  = neg_reg;
        cmd.magnitude = mag_reg;

        priority if (item.op)
        begin
            cmd.kind = CMD_TICK;
        end
        else if ((ch == CH_LF) || (ch == CH_CR))
        begin
            if (count_reg != '0)
            begin
                if ((phase_reg == PH_DIGITS) || (phase_reg == PH_DONE))
                    cmd.kind = CMD_READING;
                count_next = '0;
                phase_next = PH_SKIP;
                neg_next   = 1'b0;
                mag_next   = '0;
            end
        end
        else if (count_reg < CNT_LAST)
        begin
            count_next = count_reg + 1'b1;
            if (ch == CH_NUL)
            begin
                // NUL ends the parse
                if (phase_reg == PH_DIGITS)
                    phase_next = PH_DONE;
                else if (phase_reg != PH_DONE)
                    phase_next = PH_FAIL;
            end
            else if ((phase_reg == PH_SKIP) || (phase_reg == PH_SIGN) ||
                     (phase_reg == PH_DIGITS))
            begin
                priority if (is_digit)
                begin
                    mag_next   = mag_acc;
                    phase_next = PH_DIGITS;
                end
                else if (phase_reg == PH_DIGITS)
                    phase_next = PH_DONE;
                else if ((phase_reg == PH_SKIP) && is_blank)
                    phase_next = PH_SKIP;
                else if ((phase_reg == PH_SKIP) && ((ch == CH_PLUS) || (ch == CH_MINUS)))
                begin
                    neg_next   = (ch == CH_MINUS);
                    phase_next = PH_SIGN;
                end
                else
                    phase_next = PH_FAIL;
            end
        end
        else
        begin
            // overflowing byte: drop it and restart the line
            count_next = '0;
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
            mag_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
        end
    end

endmodule

### rtl/core/sdfr_queue.sv
module sdfr_queue
    import sdfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_FULL);
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/core/sdfr_back.sv
module sdfr_back
    import sdfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // Stage 1: partial products
    logic        s1_valid_reg;
    cmd_kind_t   s1_kind_reg;
    logic        s1_pneg_reg;
    logic [31:0] s1_raw_reg;
    logic [47:0] s1_hi_reg;
    logic [55:0] s1_lo_reg;

    // Stage 2: rounded, signed product
    logic               s2_valid_reg;
    cmd_kind_t          s2_kind_reg;
    logic [31:0]        s2_raw_reg;
    logic signed [48:0] s2_prod_reg;

    // Output stage and held values
    logic        out_valid_reg;
    logic        reading_valid_reg;
    logic        connected_reg;
    logic [31:0] raw_reg;
    logic [31:0] force_reg;
    logic [15:0] ticks_reg;

    logic               advance;
    logic [31:0]        mul_mag;
    logic [31:0]        raw_next;
    logic [56:0]        lo_round;
    logic [47:0]        q;
    logic signed [49:0] sum;
    logic [31:0]        force_next;
    logic [15:0]        ticks_next;

    // Whole pipeline moves when the output slot frees up
    assign advance = !out_valid_reg || result_ready;
    assign pop     = advance;

    // Positive counts clamp to 2^31-1; the clamped value also feeds the product
    assign mul_mag  = (!cmd.negative && (cmd.magnitude > RAW_POS_MAX)) ? RAW_POS_MAX
                    : cmd.magnitude;

    // Raw count clamped to the signed range
    assign raw_next = cmd.negative ? (32'd0 - cmd.magnitude) : mul_mag;

    // Round the low product to Q16.16, nearest with ties away from zero
    assign lo_round = {1'b0, s1_lo_reg} + 57'h80_0000;
    assign q        = s1_hi_reg + {15'd0, lo_round[56:24]};

    // Offset add and saturation
    assign sum = {s2_prod_reg[48], s2_prod_reg} +
                 {{27{cfg.offset_q16[22]}}, cfg.offset_q16};

    always_comb
    begin
        priority if (sum > 50'sd2147483647)
            force_next = 32'h7FFF_FFFF;
        else if (sum < -50'sd2147483648)
            force_next = 32'h8000_0000;
        else
            force_next = sum[31:0];
    end

    // Tick counter: cleared by a reading, saturating on ticks
    always_comb
    begin
        ticks_next = ticks_reg;
        unique case (s2_kind_reg)
            CMD_TICK:    ticks_next = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 1'b1;
            CMD_READING: ticks_next = '0;
            default:     ticks_next = ticks_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            reading_valid_reg <= 1'b0;
            connected_reg     <= 1'b0;
            raw_reg           <= '0;
            force_reg         <= '0;
            ticks_reg         <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= cmd_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                reading_valid_reg <= (s2_kind_reg == CMD_READING);
                connected_reg     <= (ticks_next < cfg.timeout_ms);
                ticks_reg         <= ticks_next;
                if (s2_kind_reg == CMD_READING)
                begin
                    raw_reg   <= s2_raw_reg;
                    force_reg <= force_next;
                end
            end
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg <= cmd.kind;
            s1_pneg_reg <= cfg.scale_neg ^ cmd.negative;
            s1_raw_reg  <= raw_next;
            s1_hi_reg   <= {16'd0, mul_mag} * {32'd0, cfg.scale_mag[39:24]};
            s1_lo_reg   <= {24'd0, mul_mag} * {32'd0, cfg.scale_mag[23:0]};

            s2_kind_reg <= s1_kind_reg;
            s2_raw_reg  <= s1_raw_reg;
            s2_prod_reg <= s1_pneg_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
    end

    assign result_valid         = out_valid_reg;
    assign result.reading_valid = reading_valid_reg;
    assign result.raw_value     = $signed(raw_reg);
    assign result.force_q16     = $signed(force_reg);
    assign result.connected     = connected_reg;

endmodule
